// ----- sv/umsf_pkg.sv -----
`default_nettype none

package umsf_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned LenW   = 3;
  localparam int unsigned CntW   = 2;
  localparam int unsigned HeldN  = 3;
  localparam int unsigned BundleN = 4;

  localparam logic [ByteW-1:0] ContMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContCode  = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Code = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Code = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Code = 8'hF0;
  localparam logic [ByteW-1:0] LeadBody  = 8'h7F;

  localparam logic [LenW-1:0] LenNone = 3'd0;
  localparam logic [LenW-1:0] Len2    = 3'd2;
  localparam logic [LenW-1:0] Len3    = 3'd3;
  localparam logic [LenW-1:0] Len4    = 3'd4;

  localparam logic [CpW-1:0] CpVs15     = 21'h00FE0E;
  localparam logic [CpW-1:0] CpVs16     = 21'h00FE0F;
  localparam logic [CpW-1:0] CpZwj      = 21'h00200D;
  localparam logic [CpW-1:0] CpKeycap   = 21'h0020E3;
  localparam logic [CpW-1:0] CpToneLo   = 21'h01F3FB;
  localparam logic [CpW-1:0] CpToneHi   = 21'h01F3FF;
  localparam logic [CpW-1:0] CpTagLo    = 21'h0E0020;
  localparam logic [CpW-1:0] CpTagHi    = 21'h0E007F;

  function automatic logic is_hidden(input logic [CpW-1:0] cp);
    return cp inside {CpVs15, CpVs16, CpZwj, CpKeycap,
                      [CpToneLo:CpToneHi], [CpTagLo:CpTagHi]};
  endfunction

endpackage

`default_nettype wire

// ----- sv/utf8_modifier_strip_filter_core.sv -----
// results of an input beat are registered and appear in the cycle after it is taken
// throughput: one input beat per cycle while the output is ready and each beat yields at most one result
// an input beat yielding n results (n up to 4) holds off further input until
// the output bundle has sent all n, one beat per cycle while the output is ready
// reset: asynchronous active low; clears pending sequence and output valid
`default_nettype none

module utf8_modifier_strip_filter_core (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire  [umsf_pkg::ByteW-1:0] in_byte_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic [umsf_pkg::ByteW-1:0] out_byte_o,
  output logic                       run_end_o,
  output logic                       string_end_o
);
  import umsf_pkg::*;

  // pending sequence
  logic [LenW-1:0]  exp_len_q, exp_len_d;
  logic [CntW-1:0]  rcv_q, rcv_d;
  logic [CpW-1:0]   acc_q, acc_d;
  logic [ByteW-1:0] held_q [HeldN];
  logic             held_we;
  logic [CntW-1:0]  held_idx;

  // output bundle
  logic             out_valid_q;
  logic [CntW-1:0]  rem_q;
  logic [ByteW-1:0] bnd_q [BundleN];
  logic             str_end_q;

  logic             has_res;
  logic [CntW-1:0]  rem_d;
  logic [ByteW-1:0] bnd_d [BundleN];
  logic             str_end_d;

  logic             is_cont;
  logic [CpW-1:0]   cp_next;
  logic [LenW-1:0]  lead_len;
  logic             take, last, in_acc;

  assign is_cont = (in_byte_i & ContMask) == ContCode;
  assign cp_next = {acc_q[CpW-7:0], in_byte_i[5:0]};

  always_comb begin
    if ((in_byte_i & Lead2Mask) == Lead2Code) begin
      lead_len = Len2;
    end else if ((in_byte_i & Lead3Mask) == Lead3Code) begin
      lead_len = Len3;
    end else if ((in_byte_i & Lead4Mask) == Lead4Code) begin
      lead_len = Len4;
    end else begin
      lead_len = LenNone;
    end
  end

  always_comb begin
    exp_len_d = LenNone;
    rcv_d     = '0;
    acc_d     = '0;
    held_we   = 1'b0;
    held_idx  = '0;
    has_res   = 1'b0;
    rem_d     = '0;
    str_end_d = 1'b0;
    for (int i = 0; i < BundleN; i++) begin
      bnd_d[i] = in_byte_i;
    end

    if (in_byte_i == '0) begin
      has_res   = 1'b1;
      str_end_d = 1'b1;
    end else if (exp_len_q != LenNone && is_cont) begin
      if ({1'b0, rcv_q} + 3'd1 < exp_len_q) begin
        held_we   = 1'b1;
        held_idx  = rcv_q;
        exp_len_d = exp_len_q;
        rcv_d     = rcv_q + 2'd1;
        acc_d     = cp_next;
      end else if (!is_hidden(cp_next)) begin
        // sequence complete and visible
        has_res = 1'b1;
        rem_d   = rcv_q;
        for (int i = 0; i < HeldN; i++) begin
          if (CntW'(i) < rcv_q) begin
            bnd_d[i] = held_q[i];
          end
        end
      end
    end else if (!in_byte_i[ByteW-1]) begin
      has_res = 1'b1;
    end else if (lead_len != LenNone) begin
      held_we   = 1'b1;
      exp_len_d = lead_len;
      rcv_d     = 2'd1;
      acc_d     = {{(CpW-ByteW){1'b0}}, in_byte_i & (LeadBody >> lead_len)};
    end
  end

  assign take       = out_valid_q && out_ready_i;
  assign last       = rem_q == '0;
  assign in_ready_o = !out_valid_q || (take && last);
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q   <= LenNone;
      rcv_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
    end else begin
      if (in_acc) begin
        exp_len_q   <= exp_len_d;
        rcv_q       <= rcv_d;
        acc_q       <= acc_d;
        out_valid_q <= has_res;
        rem_q       <= rem_d;
      end else if (take) begin
        if (last) begin
          out_valid_q <= 1'b0;
        end else begin
          rem_q <= rem_q - 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && held_we) begin
      held_q[held_idx] <= in_byte_i;
    end
    if (in_acc) begin
      str_end_q <= str_end_d;
      for (int i = 0; i < BundleN; i++) begin
        bnd_q[i] <= bnd_d[i];
      end
    end else if (take && !last) begin
      // next beat of the bundle moves to the front
      for (int i = 0; i < BundleN - 1; i++) begin
        bnd_q[i] <= bnd_q[i+1];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = bnd_q[0];
  assign run_end_o    = last;
  assign string_end_o = str_end_q;

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_len_q == LenNone |-> rcv_q == '0)
    else $error("count held with no sequence pending");

  a_pend_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_len_q != LenNone |-> rcv_q != '0 && {1'b0, rcv_q} < exp_len_q)
    else $error("pending count out of range");

  a_pend_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_len_q == LenNone || exp_len_q == Len2 || exp_len_q == Len3 || exp_len_q == Len4)
    else $error("bad sequence length");

  a_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_byte_i == '0 |=> out_valid_o && string_end_o && run_end_o
      && out_byte_o == '0)
    else $error("terminator beat missing");

endmodule

`default_nettype wire
